@@ hw/rtl/ppp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, constants and the arctangent table of the point pair core.
// ----------------------------------------------------------------------------
package ppp_pkg;

    // Width of the scaled rotation datapath (x and y of the vectoring cells).
    localparam int XW = 62;
    // Width of the angle accumulator, in units of 2^-16 degree.
    localparam int ZW = 28;
    // Quotient bits of the direction ratios (Q1.14 magnitude, at most 16384).
    localparam int QW = 15;
    // Number of table entries of the vectoring cells.
    localparam int MAX_STEPS = 24;
    // Fixed scale of the coordinates inside the vectoring datapath.
    localparam int SCALE_BASE = 58;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] ANGLE_ROUND  = ZW'(512);
    localparam int                   ANGLE_SHIFT  = 10;
    localparam logic signed [ZW-1:0] ANGLE_LIMIT  = ZW'(11520);

    // atan(2^-i) in degrees, units of 2^-16 degree.
    localparam logic signed [ZW-1:0] ATAN_TABLE [MAX_STEPS] = '{
        ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
        ZW'(234379),  ZW'(117304),  ZW'(58666),  ZW'(29335),
        ZW'(14668),   ZW'(7334),    ZW'(3667),   ZW'(1833),
        ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),
        ZW'(57),      ZW'(29),      ZW'(14),     ZW'(7),
        ZW'(4),       ZW'(2),       ZW'(1),      ZW'(0)
    };

    // One finished result as it sits in the output buffer.
    typedef struct packed {
        logic               degenerate;
        logic signed [15:0] sine_ratio;
        logic signed [15:0] cosine_ratio;
        logic signed [14:0] angle_degrees;
        logic        [16:0] distance;
        logic signed [16:0] delta_y;
        logic signed [16:0] delta_x;
    } ppp_result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ppp_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_sqrt_cell
// One digit of the integer square root: a compare and subtract per cell.
// ----------------------------------------------------------------------------
module ppp_sqrt_cell #(
    parameter int RW      = 34,
    parameter int BIT_POS = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [RW-1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    output logic      [RW-1:0] rem_out,
    output logic      [RW-1:0] root_out
);

    localparam logic [RW:0] BIT_VAL = (RW+1)'(1) << BIT_POS;

    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW:0]   trial;

    always_comb
    begin
        trial = {1'b0, root_in} + BIT_VAL;
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next  = rem_in - trial[RW-1:0];
            root_next = (root_in >> 1) + BIT_VAL[RW-1:0];
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ppp_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_cordic_cell
// One vectoring rotation: drives y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module ppp_cordic_cell
    import ppp_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [XW-1:0] x_in,
    input  wire logic signed [XW-1:0] y_in,
    input  wire logic signed [ZW-1:0] z_in,
    output logic signed      [XW-1:0] x_out,
    output logic signed      [XW-1:0] y_out,
    output logic signed      [ZW-1:0] z_out
);

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next;

    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_TABLE[STEP];
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_TABLE[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ppp_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_div_cell
// One quotient bit of both direction ratios, restoring division.
// ----------------------------------------------------------------------------
module ppp_div_cell
    import ppp_pkg::*;
#(
    parameter int NW    = 33,
    parameter int DEN_W = 19,
    parameter int SHIFT = 0
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NW-1:0]    rem_x_in,
    input  wire logic [NW-1:0]    rem_y_in,
    input  wire logic [QW-1:0]    q_x_in,
    input  wire logic [QW-1:0]    q_y_in,
    input  wire logic [DEN_W-1:0] den_in,
    output logic      [NW-1:0]    rem_x_out,
    output logic      [NW-1:0]    rem_y_out,
    output logic      [QW-1:0]    q_x_out,
    output logic      [QW-1:0]    q_y_out,
    output logic      [DEN_W-1:0] den_out
);

    localparam logic [QW-1:0] Q_BIT = QW'(1) << SHIFT;

    logic [NW-1:0]    den_sh;
    logic [NW-1:0]    rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QW-1:0]    q_x_reg, q_x_next, q_y_reg, q_y_next;
    logic [DEN_W-1:0] den_reg;

    always_comb
    begin
        den_sh     = NW'(den_in) << SHIFT;
        rem_x_next = rem_x_in;
        rem_y_next = rem_y_in;
        q_x_next   = q_x_in;
        q_y_next   = q_y_in;
        if (rem_x_in >= den_sh)
        begin
            rem_x_next = rem_x_in - den_sh;
            q_x_next   = q_x_in | Q_BIT;
        end
        if (rem_y_in >= den_sh)
        begin
            rem_y_next = rem_y_in - den_sh;
            q_y_next   = q_y_in | Q_BIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
            den_reg   <= den_in;
        end
    end

    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign q_x_out   = q_x_reg;
    assign q_y_out   = q_y_reg;
    assign den_out   = den_reg;

endmodule
`default_nettype wire

@@ hw/rtl/point_pair_polar_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Root digits: K = ceil(min(2*COORD_BITS+1, 64) / 2), one per square root cell.
// Throughput: one transfer per cycle; the pipeline of cells advances every
// cycle unless the two-entry output buffer is full.
// Reset: rst_n clears the valid bits and the output buffer pointers at once;
// the data registers hold whatever they held.
// ----------------------------------------------------------------------------
// point_pair_polar_core
// Offset, distance, direction angle and direction cosine/sine of two points.
// ----------------------------------------------------------------------------
module point_pair_polar_core
    import ppp_pkg::*;
#(
    parameter int ROTATION_STEPS = 16,
    parameter int COORD_BITS     = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // base_x [15:0], base_y [31:16], other_x [47:32], other_y [63:48]
    input  wire logic [63:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // delta_x [16:0], delta_y [33:17], distance [50:34], angle_degrees [65:51],
    // cosine_ratio [81:66], sine_ratio [97:82], zero fill [103:98]
    output logic [103:0]      m_axis_tdata,
    // degenerate [0]
    output logic [0:0]        m_axis_tuser
);

    // Derived widths. The coordinates are taken as COORD_BITS wide words.
    localparam int CW     = COORD_BITS;
    localparam int DW     = CW + 1;                        // offset
    localparam int MW     = CW;                            // offset magnitude
    localparam int SQ_W   = 2 * MW;                        // one square
    localparam int SW     = (2 * MW + 1 > 64) ? 64 : 2 * MW + 1;
    localparam int K      = (SW + 1) / 2;                  // root digits
    localparam int RW     = 2 * K;
    localparam int DIST_W = K + 1;
    localparam int DEN_W  = K + 2;
    localparam int NW     = (CW + 16 > K + 17) ? CW + 16 : K + 17;
    localparam int S      = (ROTATION_STEPS > MAX_STEPS) ? MAX_STEPS : ROTATION_STEPS;
    localparam int SS     = SCALE_BASE - CW;

    // Pipeline layers. Layer 1 holds the offset of a freshly accepted item.
    localparam int L_DIST    = 4 + K;
    localparam int LAST      = 20 + K;
    localparam int ANG_FIRST = 3 + S;

    // The whole chain of cells steps together; it only halts when the
    // output buffer cannot take another result.
    logic       en;
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;

    assign en            = (count_reg != 2'd2);
    assign s_axis_tready = en;

    // ---------------------------------------------------------------- layer 1
    logic        [CW-1:0] bx, by, ox, oy;
    logic signed [DW-1:0] dx_next, dy_next;

    assign bx      = CW'(s_axis_tdata[15:0]);
    assign by      = CW'(s_axis_tdata[31:16]);
    assign ox      = CW'(s_axis_tdata[47:32]);
    assign oy      = CW'(s_axis_tdata[63:48]);
    assign dx_next = $signed({ox[CW-1], ox}) - $signed({bx[CW-1], bx});
    assign dy_next = $signed({oy[CW-1], oy}) - $signed({by[CW-1], by});

    // Valid bits and the delay lines that carry the offset to the end.
    logic                 v_reg     [1:LAST];
    logic signed [DW-1:0] dx_pipe_reg [1:LAST];
    logic signed [DW-1:0] dy_pipe_reg [1:LAST];
    logic                 degen_pipe_reg [1:LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[1] <= s_axis_tvalid;
            for (int i = 2; i <= LAST; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_pipe_reg[1]    <= dx_next;
            dy_pipe_reg[1]    <= dy_next;
            degen_pipe_reg[1] <= (dx_next == '0) && (dy_next == '0);
            for (int i = 2; i <= LAST; i++)
            begin
                dx_pipe_reg[i]    <= dx_pipe_reg[i-1];
                dy_pipe_reg[i]    <= dy_pipe_reg[i-1];
                degen_pipe_reg[i] <= degen_pipe_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------- squares and sum
    logic [MW-1:0]   mag_x1, mag_y1;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [SW-1:0]   n_reg;

    assign mag_x1 = dx_pipe_reg[1][DW-1] ? MW'(-dx_pipe_reg[1]) : MW'(dx_pipe_reg[1]);
    assign mag_y1 = dy_pipe_reg[1][DW-1] ? MW'(-dy_pipe_reg[1]) : MW'(dy_pipe_reg[1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= mag_x1 * mag_x1;
            sqy_reg <= mag_y1 * mag_y1;
            // The sum wraps to 64 bits at the widest coordinate setting.
            n_reg   <= SW'({1'b0, sqx_reg} + {1'b0, sqy_reg});
        end
    end

    // ---------------------------------------------------- square root cells
    // Cell j settles one root digit; the trial bit is 4^(K-j).
    logic [RW-1:0] rem_w  [0:K];
    logic [RW-1:0] root_w [0:K];

    assign rem_w[0]  = RW'(n_reg);
    assign root_w[0] = '0;

    for (genvar j = 1; j <= K; j++)
    begin : g_sqrt
        ppp_sqrt_cell #(
            .RW      (RW),
            .BIT_POS (2 * (K - j))
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (rem_w[j-1]),
            .root_in  (root_w[j-1]),
            .rem_out  (rem_w[j]),
            .root_out (root_w[j])
        );
    end

    // Round to nearest: the remainder exceeds the root exactly when the true
    // root lies above the half way point.
    logic [DIST_W-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= DIST_W'(root_w[K]) + DIST_W'(rem_w[K] > root_w[K]);
        end
    end

    // ------------------------------------------------------ division setup
    // ratio = floor((2*mag*16384 + dist) / (2*dist)), worked as
    // (mag*2^15 + dist) over 2*dist.
    logic [MW-1:0]    mag_xd, mag_yd;
    logic [NW-1:0]    num_x_reg, num_y_reg;
    logic [DEN_W-1:0] den_reg;

    assign mag_xd = dx_pipe_reg[L_DIST][DW-1] ?
                    MW'(-dx_pipe_reg[L_DIST]) : MW'(dx_pipe_reg[L_DIST]);
    assign mag_yd = dy_pipe_reg[L_DIST][DW-1] ?
                    MW'(-dy_pipe_reg[L_DIST]) : MW'(dy_pipe_reg[L_DIST]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg <= (NW'(mag_xd) << QW) + NW'(dist_reg);
            num_y_reg <= (NW'(mag_yd) << QW) + NW'(dist_reg);
            den_reg   <= {dist_reg, 1'b0};
        end
    end

    // --------------------------------------------------------- divider cells
    logic [NW-1:0]    d_rem_x [0:QW];
    logic [NW-1:0]    d_rem_y [0:QW];
    logic [QW-1:0]    d_q_x   [0:QW];
    logic [QW-1:0]    d_q_y   [0:QW];
    logic [DEN_W-1:0] d_den   [0:QW];

    assign d_rem_x[0] = num_x_reg;
    assign d_rem_y[0] = num_y_reg;
    assign d_q_x[0]   = '0;
    assign d_q_y[0]   = '0;
    assign d_den[0]   = den_reg;

    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        ppp_div_cell #(
            .NW    (NW),
            .DEN_W (DEN_W),
            .SHIFT (QW - j)
        ) u_cell (
            .clk       (clk),
            .en        (en),
            .rem_x_in  (d_rem_x[j-1]),
            .rem_y_in  (d_rem_y[j-1]),
            .q_x_in    (d_q_x[j-1]),
            .q_y_in    (d_q_y[j-1]),
            .den_in    (d_den[j-1]),
            .rem_x_out (d_rem_x[j]),
            .rem_y_out (d_rem_y[j]),
            .q_x_out   (d_q_x[j]),
            .q_y_out   (d_q_y[j]),
            .den_out   (d_den[j])
        );
    end

    // -------------------------------------------------------- angle cells
    // Pre-rotation by a quarter turn folds the left half plane onto the
    // right one, then S vectoring cells follow.
    logic signed [XW-1:0] sx, sy;
    logic signed [XW-1:0] c_x [0:S];
    logic signed [XW-1:0] c_y [0:S];
    logic signed [ZW-1:0] c_z [0:S];
    logic signed [XW-1:0] pre_x_reg, pre_y_reg;
    logic signed [ZW-1:0] pre_z_reg;

    assign sx = XW'(dx_pipe_reg[1]) <<< SS;
    assign sy = XW'(dy_pipe_reg[1]) <<< SS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sx < 0)
            begin
                if (sy >= 0)
                begin
                    pre_x_reg <= sy;
                    pre_y_reg <= -sx;
                    pre_z_reg <= QUARTER_TURN;
                end
                else
                begin
                    pre_x_reg <= -sy;
                    pre_y_reg <= sx;
                    pre_z_reg <= -QUARTER_TURN;
                end
            end
            else
            begin
                pre_x_reg <= sx;
                pre_y_reg <= sy;
                pre_z_reg <= '0;
            end
        end
    end

    assign c_x[0] = pre_x_reg;
    assign c_y[0] = pre_y_reg;
    assign c_z[0] = pre_z_reg;

    for (genvar i = 0; i < S; i++)
    begin : g_cordic
        ppp_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .en    (en),
            .x_in  (c_x[i]),
            .y_in  (c_y[i]),
            .z_in  (c_z[i]),
            .x_out (c_x[i+1]),
            .y_out (c_y[i+1]),
            .z_out (c_z[i+1])
        );
    end

    // Round the accumulated angle to Q9.6 and clamp it to half a turn, then
    // carry it to the end of the chain.
    logic signed [ZW-1:0] ang_q, ang_sat;
    logic signed [14:0]   ang_pipe_reg [ANG_FIRST:LAST];

    always_comb
    begin
        ang_q = (c_z[S] + ANGLE_ROUND) >>> ANGLE_SHIFT;
        if (ang_q > ANGLE_LIMIT)
        begin
            ang_sat = ANGLE_LIMIT;
        end
        else if (ang_q < -ANGLE_LIMIT)
        begin
            ang_sat = -ANGLE_LIMIT;
        end
        else
        begin
            ang_sat = ang_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_pipe_reg[ANG_FIRST] <= 15'(ang_sat);
            for (int i = ANG_FIRST + 1; i <= LAST; i++)
            begin
                ang_pipe_reg[i] <= ang_pipe_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------ result assembly
    // Coinciding points (and a zero root) force angle and ratios to zero.
    ppp_result_t          res;
    logic                 kill;
    logic signed [15:0]   qx_s, qy_s;

    assign kill = degen_pipe_reg[LAST] || (d_den[QW] == '0);
    assign qx_s = 16'(d_q_x[QW]);
    assign qy_s = 16'(d_q_y[QW]);

    always_comb
    begin
        res.delta_x    = 17'(dx_pipe_reg[LAST]);
        res.delta_y    = 17'(dy_pipe_reg[LAST]);
        res.distance   = 17'(d_den[QW][DEN_W-1:1]);
        res.degenerate = degen_pipe_reg[LAST];
        if (kill)
        begin
            res.angle_degrees = '0;
            res.cosine_ratio  = '0;
            res.sine_ratio    = '0;
        end
        else
        begin
            res.angle_degrees = ang_pipe_reg[LAST];
            res.cosine_ratio  = dx_pipe_reg[LAST][DW-1] ? -qx_s : qx_s;
            res.sine_ratio    = dy_pipe_reg[LAST][DW-1] ? -qy_s : qy_s;
        end
    end

    // --------------------------------------------------------- output buffer
    // Two entries, so that a new item still enters while a result waits.
    ppp_result_t buf_reg [2];

    assign push = en && v_reg[LAST];
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

    ppp_result_t head;

    assign head          = buf_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = {6'd0, head.sine_ratio, head.cosine_ratio,
                            head.angle_degrees, head.distance,
                            head.delta_y, head.delta_x};
    assign m_axis_tuser  = head.degenerate;

endmodule
`default_nettype wire

@@ hw/rtl/ppp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks of the point pair core, bound to the top level.
// ----------------------------------------------------------------------------
module ppp_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [63:0]  s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata,
    input wire logic [0:0]   m_axis_tuser
);

    // A stalled result stays offered and unchanged.
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed or dropped");

    // Coinciding points give a zero offset, distance, angle and ratios.
    a_degen : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[97:0] == '0)
        else $error("degenerate result carries nonzero fields");

    // Direction cosine stays within plus or minus one.
    a_cos : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        ($signed(m_axis_tdata[81:66]) <= 16'sd16384) &&
        ($signed(m_axis_tdata[81:66]) >= -16'sd16384))
        else $error("cosine ratio out of range");

    // The angle is clamped to half a turn.
    a_angle : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        ($signed(m_axis_tdata[65:51]) <= 15'sd11520) &&
        ($signed(m_axis_tdata[65:51]) >= -15'sd11520))
        else $error("angle out of range");

endmodule

bind point_pair_polar_core ppp_checker u_ppp_checker (.*);
`default_nettype wire
